FILE: hw/rtl/cvcc_pkg.sv
// Package for the CV to MIDI CC converter.
// Types, codes and constants shared by all RTL files; no dependencies.
`default_nettype none

package cvcc_pkg;

  localparam int NUM_CH = 16;
  localparam int NUM_CC = 128;

  localparam int ACTION_W  = 2;
  localparam int CHANNEL_W = 4;
  localparam int MV_W      = 15;
  localparam int SEL_W     = 8;
  localparam int FRAME_W   = 48;
  localparam int STATUS_W  = 8;
  localparam int CC_W      = 7;
  localparam int VAL_W     = 7;
  localparam int PERIOD_W  = 16;
  localparam int MIDI_CH_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int MAP_W     = 8;

  localparam logic [MAP_W-1:0] NO_CC = 8'hFF;
  localparam logic [3:0] CC_STATUS_HI = 4'hB;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd240;

  // quantizer: q = floor((mv*127 + 5000) / 10000), via reciprocal multiply
  localparam int X_W     = 21;
  localparam int PROD_W  = 42;
  localparam int Q_SHIFT = 34;
  localparam logic [X_W-1:0] Q_BIAS  = 21'd5000;
  localparam logic [X_W-1:0] Q_RECIP = 21'd1717987;
  localparam logic [MV_W-2:0] MV_SAT = 14'd10040;
  localparam logic [VAL_W-1:0] VAL_MAX = 7'd127;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FRAME  = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_LEARN  = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 1'b0,
    CFG_MIDI   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [CC_W-1:0]  addr;
    logic [VAL_W-1:0] wdata;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cvcc_sent_ram.sv
// Last-sent value table: one value per CC number, synchronous read.
// Per-entry valid bits mark entries never sent. Uses cvcc_pkg.
`default_nettype none

module cvcc_sent_ram (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cvcc_pkg::ram_req_t        req_i,
  output      logic [cvcc_pkg::VAL_W-1:0] rdata_o,
  output      logic                      rvalid_o
);
  import cvcc_pkg::*;

  logic [VAL_W-1:0] mem [NUM_CC];
  logic [NUM_CC-1:0] vld_q;
  logic [VAL_W-1:0] rdata_q;
  logic rvalid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rvalid_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign rvalid_o = rvalid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cvcc_quant.sv
// Voltage quantizer: mV to 0..127, round half up, clamped.
// Two registered stages: scale and bias, then reciprocal multiply. Uses cvcc_pkg.
`default_nettype none

module cvcc_quant (
  input  wire logic                        clk_i,
  input  wire logic                        load_i,
  input  wire logic [cvcc_pkg::MV_W-1:0]   voltage_mv_i,
  output      logic [cvcc_pkg::VAL_W-1:0]  q_o
);
  import cvcc_pkg::*;

  logic [MV_W-2:0] mv_u;
  logic            pos;
  logic [X_W-1:0]  scaled;
  logic [X_W-1:0]  x_d, x_q;
  logic            sat_d, sat_q, sat2_q;
  logic [PROD_W-1:0] prod_q;

  always_comb begin
    mv_u   = voltage_mv_i[MV_W-2:0];
    pos    = !voltage_mv_i[MV_W-1] && (mv_u != '0);
    scaled = {mv_u, 7'b0} - X_W'(mv_u);
    x_d    = pos ? scaled + Q_BIAS : '0;
    sat_d  = pos && (mv_u >= MV_SAT);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q   <= x_d;
      sat_q <= sat_d;
    end
    prod_q <= PROD_W'(x_q) * PROD_W'(Q_RECIP);
    sat2_q <= sat_q;
  end

  assign q_o = sat2_q ? VAL_MAX : prod_q[Q_SHIFT+VAL_W-1:Q_SHIFT];

endmodule

`default_nettype wire

FILE: hw/rtl/cv_to_midi_cc_converter.sv
// CV to MIDI CC converter, top level. Uses cvcc_pkg, cvcc_quant, cvcc_sent_ram.
// Frame and learn items are handled as they are accepted; a sample passes through accept and
// table read, reciprocal multiply, then compare and write-back, matching the two-stage quantizer;
// the compare waits while the output register is full and stalled, and no new item is taken meanwhile.
// A result sits in an output register; the next item is taken while it waits.
// Reset (async, active low): every CC marked never sent at once, channel i
// mapped to CC i, rate limiter and scan cleared; no clearing pass.
`default_nettype none

module cv_to_midi_cc_converter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cvcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cvcc_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output      logic                            in_stall_o,
  input  wire logic [cvcc_pkg::ACTION_W-1:0]   action_i,
  input  wire logic [cvcc_pkg::CHANNEL_W-1:0]  channel_i,
  input  wire logic [cvcc_pkg::MV_W-1:0]       voltage_mv_i,
  input  wire logic [cvcc_pkg::SEL_W-1:0]      cc_select_i,
  input  wire logic [cvcc_pkg::FRAME_W-1:0]    frame_number_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  output      logic [cvcc_pkg::STATUS_W-1:0]   status_byte_o,
  output      logic [cvcc_pkg::CC_W-1:0]       cc_number_o,
  output      logic [cvcc_pkg::VAL_W-1:0]      cc_value_o,
  output      logic [cvcc_pkg::FRAME_W-1:0]    frame_stamp_o
);
  import cvcc_pkg::*;

  state_e state_q, state_d;

  logic [PERIOD_W-1:0]  period_q;
  logic [MIDI_CH_W-1:0] midi_q;
  logic [PERIOD_W-1:0]  limit_q;
  logic                 scan_open_q;
  logic [FRAME_W-1:0]   scan_frame_q;
  logic [MAP_W-1:0]     map_q [NUM_CH];
  logic [CC_W-1:0]      cur_cc_q;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q;
  logic [CC_W-1:0]      out_cc_q;
  logic [VAL_W-1:0]     out_val_q;
  logic [FRAME_W-1:0]   out_frame_q;

  logic                 in_fire, ch_ok, sample_go, out_free, send;
  logic [PERIOD_W-1:0]  limit_inc, period_eff;
  logic [MAP_W-1:0]     map_sel;
  logic [VAL_W-1:0]     q, last_val;
  logic                 last_vld;
  ram_req_t             ram_req;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign ch_ok    = int'(channel_i) < NUM_CH;
  assign map_sel  = map_q[channel_i];
  assign sample_go = in_fire && (action_i == ACT_SAMPLE) && ch_ok && scan_open_q &&
                     (map_sel != NO_CC);
  assign out_free = !out_valid_q || !out_stall_i;
  assign send     = !last_vld || (last_val != q);
  assign limit_inc  = limit_q + 1'b1;
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

  cvcc_quant u_quant (
    .clk_i        (clk_i),
    .load_i       (sample_go),
    .voltage_mv_i (voltage_mv_i),
    .q_o          (q)
  );

  cvcc_sent_ram u_sent (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ram_req),
    .rdata_o  (last_val),
    .rvalid_o (last_vld)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sample_go) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_CMP;
      ST_CMP: begin
        if (!send || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o    = 1'b1;
    ram_req.rd_en = 1'b0;
    ram_req.wr_en = 1'b0;
    ram_req.addr  = cur_cc_q;
    ram_req.wdata = q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        ram_req.rd_en = sample_go;
        ram_req.addr  = map_sel[CC_W-1:0];
      end
      ST_MUL: ;
      ST_CMP: ram_req.wr_en = send && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      period_q     <= PERIOD_RST;
      midi_q       <= '0;
      limit_q      <= '0;
      scan_open_q  <= 1'b0;
      scan_frame_q <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        map_q[i] <= {1'b0, CC_W'(i)};
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PERIOD: period_q <= cfg_wdata_i[PERIOD_W-1:0];
          CFG_MIDI:   midi_q   <= cfg_wdata_i[MIDI_CH_W-1:0];
          default: ;
        endcase
      end
      if (in_fire && (action_i == ACT_FRAME)) begin
        if (limit_inc >= period_eff) begin
          limit_q      <= '0;
          scan_open_q  <= 1'b1;
          scan_frame_q <= frame_number_i;
        end else begin
          limit_q     <= limit_inc;
          scan_open_q <= 1'b0;
        end
      end
      if (in_fire && (action_i == ACT_LEARN) && ch_ok) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (CHANNEL_W'(i) == channel_i) begin
            map_q[i] <= cc_select_i[SEL_W-1] ? NO_CC : cc_select_i;
          end else if (!cc_select_i[SEL_W-1] && (map_q[i] == cc_select_i)) begin
            map_q[i] <= NO_CC;
          end
        end
      end
      if (ram_req.wr_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_go) begin
      cur_cc_q <= map_sel[CC_W-1:0];
    end
    if (ram_req.wr_en) begin
      status_q    <= {CC_STATUS_HI, midi_q};
      out_cc_q    <= cur_cc_q;
      out_val_q   <= q;
      out_frame_q <= scan_frame_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_byte_o = status_q;
  assign cc_number_o   = out_cc_q;
  assign cc_value_o    = out_val_q;
  assign frame_stamp_o = out_frame_q;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Testbench for cv_to_midi_cc_converter: directed and random CV items with a
// built-in predictor and an in-order check of every CC message.
// Depends on cvcc_pkg and the converter RTL only.
`default_nettype none

module testbench;
  import cvcc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [CHANNEL_W-1:0] channel;
    logic [MV_W-1:0]      mv;
    logic [SEL_W-1:0]     sel;
    logic [FRAME_W-1:0]   frame;
  } cv_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CC_W-1:0]     cc;
    logic [VAL_W-1:0]    value;
    logic [FRAME_W-1:0]  stamp;
  } cc_msg_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ACTION_W-1:0]  action_i;
  logic [CHANNEL_W-1:0] channel_i;
  logic [MV_W-1:0]      voltage_mv_i;
  logic [SEL_W-1:0]     cc_select_i;
  logic [FRAME_W-1:0]   frame_number_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STATUS_W-1:0]  status_byte_o;
  logic [CC_W-1:0]      cc_number_o;
  logic [VAL_W-1:0]     cc_value_o;
  logic [FRAME_W-1:0]   frame_stamp_o;

  cv_to_midi_cc_converter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .channel_i     (channel_i),
    .voltage_mv_i  (voltage_mv_i),
    .cc_select_i   (cc_select_i),
    .frame_number_i(frame_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_byte_o (status_byte_o),
    .cc_number_o   (cc_number_o),
    .cc_value_o    (cc_value_o),
    .frame_stamp_o (frame_stamp_o)
  );

  // predictor state
  logic [MAP_W-1:0]    last_val [NUM_CC];
  logic [MAP_W-1:0]    chan_cc [NUM_CH];
  logic [PERIOD_W-1:0] frame_cnt;
  logic                scan_on;
  logic [FRAME_W-1:0]  scan_stamp;
  logic [PERIOD_W-1:0] cfg_period;
  logic [MIDI_CH_W-1:0] cfg_midi;

  cv_item_t item_queue[$];
  cc_msg_t  msg_expect[$];
  cv_item_t drv_item;
  int       queued_count;
  int       taken_count;
  int       mismatches;
  int       cycles;
  int       in_wait;
  int       out_wait;
  bit       idle_on;
  logic     in_taken;
  logic     out_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    if (!idle_on) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [VAL_W-1:0] quantize_mv(logic [MV_W-1:0] mv);
    int v;
    int q;
    v = int'($signed(mv));
    if (v <= 0) return '0;
    q = (v * 127 + 5000) / 10000;
    return (q > 127) ? VAL_MAX : q[VAL_W-1:0];
  endfunction

  task automatic reset_model();
    for (int i = 0; i < NUM_CC; i++) last_val[i] = NO_CC;
    for (int i = 0; i < NUM_CH; i++) chan_cc[i] = MAP_W'(i);
    frame_cnt  = '0;
    scan_on    = 1'b0;
    scan_stamp = '0;
    cfg_period = PERIOD_RST;
    cfg_midi   = '0;
  endtask

  task automatic predict_item(cv_item_t it);
    logic [PERIOD_W-1:0] eff;
    logic [CC_W-1:0]     cc;
    logic [VAL_W-1:0]    q;
    cc_msg_t             msg;
    case (it.action)
      ACT_FRAME: begin
        eff = (cfg_period == '0) ? PERIOD_W'(1) : cfg_period;
        frame_cnt = frame_cnt + 1'b1;
        if (frame_cnt >= eff) begin
          frame_cnt  = '0;
          scan_on    = 1'b1;
          scan_stamp = it.frame;
        end else begin
          scan_on = 1'b0;
        end
      end
      ACT_SAMPLE: begin
        if (scan_on && chan_cc[it.channel] != NO_CC) begin
          cc = chan_cc[it.channel][CC_W-1:0];
          q  = quantize_mv(it.mv);
          if ({1'b0, q} != last_val[cc]) begin
            last_val[cc] = {1'b0, q};
            msg.status = {CC_STATUS_HI, cfg_midi};
            msg.cc     = cc;
            msg.value  = q;
            msg.stamp  = scan_stamp;
            msg_expect.push_back(msg);
          end
        end
      end
      ACT_LEARN: begin
        if (it.sel[SEL_W-1]) begin
          chan_cc[it.channel] = NO_CC;
        end else begin
          for (int i = 0; i < NUM_CH; i++)
            if (chan_cc[i] == it.sel) chan_cc[i] = NO_CC;
          chan_cc[it.channel] = it.sel;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [FRAME_W-1:0] got,
                                 logic [FRAME_W-1:0] want);
    $display("mismatch at %0t, %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // monitor, then predictor: a message never leaves in the cycle its item enters
  always @(posedge clk_i) begin
    cc_msg_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
    out_taken <= rst_ni && out_valid_o && !out_stall_i;
    in_taken  <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (msg_expect.size() == 0) begin
        report_mismatch("unexpected message cc", FRAME_W'(cc_number_o),
                        FRAME_W'(cc_value_o));
      end else begin
        want = msg_expect.pop_front();
        if (status_byte_o != want.status)
          report_mismatch("status_byte", FRAME_W'(status_byte_o), FRAME_W'(want.status));
        if (cc_number_o != want.cc)
          report_mismatch("cc_number", FRAME_W'(cc_number_o), FRAME_W'(want.cc));
        if (cc_value_o != want.value)
          report_mismatch("cc_value", FRAME_W'(cc_value_o), FRAME_W'(want.value));
        if (frame_stamp_o != want.stamp)
          report_mismatch("frame_stamp", frame_stamp_o, want.stamp);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      taken_count++;
      predict_item({action_i, channel_i, voltage_mv_i, cc_select_i, frame_number_i});
    end
  end

  // input driver: holds a stalled transfer, then waits its drawn gap
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_wait != 0) begin
        in_valid_i <= 1'b0;
        in_wait = in_wait - 1;
      end else if (item_queue.size() != 0) begin
        drv_item = item_queue.pop_front();
        action_i       <= drv_item.action;
        channel_i      <= drv_item.channel;
        voltage_mv_i   <= drv_item.mv;
        cc_select_i    <= drv_item.sel;
        frame_number_i <= drv_item.frame;
        in_valid_i     <= 1'b1;
        in_wait = draw_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall: after each transfer, stall for a drawn number of cycles
  always @(negedge clk_i) begin
    if (out_taken) out_wait = draw_gap();
    if (out_wait != 0) begin
      out_stall_i <= 1'b1;
      out_wait = out_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic add_item(logic [ACTION_W-1:0] act, logic [CHANNEL_W-1:0] ch,
                          logic [MV_W-1:0] mv, logic [SEL_W-1:0] sel,
                          logic [FRAME_W-1:0] frm);
    item_queue.push_back({act, ch, mv, sel, frm});
    queued_count++;
  endtask

  function automatic logic [MV_W-1:0] pick_mv();
    int r;
    int k;
    r = $urandom_range(0, 9);
    if (r < 2) return MV_W'($urandom);
    if (r < 6) return MV_W'(int'($urandom_range(0, 24000)) - 12000);
    if (r < 8) begin
      k = $urandom_range(0, 127);
      return MV_W'((k * 10000 + 5000) / 127 + int'($urandom_range(0, 2)) - 1);
    end
    return MV_W'($urandom_range(0, 3) * 3000);
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return FRAME_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] pick_sel();
    if ($urandom_range(0, 4) == 0) return SEL_W'($urandom);
    return SEL_W'($urandom_range(0, 127));
  endfunction

  task automatic add_random_items(int n);
    int stop;
    int r;
    int k;
    stop = queued_count + n;
    while (queued_count < stop) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        add_item(ACT_LEARN, CHANNEL_W'($urandom), MV_W'($urandom), pick_sel(),
                 pick_frame());
      end else if (r < 6) begin
        add_item(ACT_NONE, CHANNEL_W'($urandom), MV_W'($urandom), SEL_W'($urandom),
                 pick_frame());
      end else if (r < 10) begin
        add_item(ACT_SAMPLE, CHANNEL_W'($urandom), pick_mv(), SEL_W'($urandom),
                 pick_frame());
      end else begin
        add_item(ACT_FRAME, CHANNEL_W'($urandom), MV_W'($urandom), SEL_W'($urandom),
                 pick_frame());
        k = $urandom_range(0, 5);
        repeat (k) add_item(ACT_SAMPLE, CHANNEL_W'($urandom), pick_mv(),
                            SEL_W'($urandom), pick_frame());
      end
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_PERIOD) cfg_period = val[PERIOD_W-1:0];
    else cfg_midi = val[MIDI_CH_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block is idle once all transfers are in, all messages out, and a few quiet cycles
  task automatic wait_drained();
    int quiet;
    quiet = 0;
    while (quiet < DRAIN_CYCLES) begin
      @(negedge clk_i);
      if (taken_count == queued_count && msg_expect.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  initial begin
    logic [PERIOD_W-1:0] period;
    int n;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    action_i       = '0;
    channel_i      = '0;
    voltage_mv_i   = '0;
    cc_select_i    = '0;
    frame_number_i = '0;
    out_stall_i    = 1'b0;
    queued_count   = 0;
    taken_count    = 0;
    mismatches     = 0;
    cycles         = 0;
    in_wait        = 0;
    out_wait       = 0;
    idle_on        = 1'b1;
    reset_model();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_reg(CFG_PERIOD, 16'd1);
    write_reg(CFG_MIDI, 16'h000F);
    @(posedge clk_i);
    add_item(ACT_SAMPLE, 4'd0, 15'd5000, SEL_W'($urandom), FRAME_W'($urandom)); // no scan yet
    add_item(ACT_FRAME, CHANNEL_W'($urandom), MV_W'($urandom), SEL_W'($urandom), '1);
    add_item(ACT_SAMPLE, 4'd0, 15'd0, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd1, -15'sd12000, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd2, 15'd12000, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd3, 15'd10000, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd4, 15'd39, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd5, 15'd40, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd6, 15'h3FFF, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd7, 15'h4000, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd0, 15'd0, SEL_W'($urandom), FRAME_W'($urandom)); // unchanged value
    add_item(ACT_SAMPLE, 4'd0, 15'd79, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_LEARN, 4'd8, MV_W'($urandom), 8'hFF, FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd8, 15'd5000, SEL_W'($urandom), FRAME_W'($urandom)); // unmapped
    add_item(ACT_LEARN, 4'd9, MV_W'($urandom), 8'd0, FRAME_W'($urandom)); // steals cc 0
    add_item(ACT_SAMPLE, 4'd0, 15'd5000, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd9, 15'd79, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd9, 15'd10000, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_LEARN, 4'd10, MV_W'($urandom), 8'd127, FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd10, 15'd5000, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_LEARN, 4'd11, MV_W'($urandom), 8'h80, FRAME_W'($urandom));
    add_item(ACT_NONE, CHANNEL_W'($urandom), MV_W'($urandom), SEL_W'($urandom),
             FRAME_W'($urandom));
    add_item(ACT_FRAME, CHANNEL_W'($urandom), MV_W'($urandom), SEL_W'($urandom), '0);
    add_item(ACT_SAMPLE, 4'd2, 15'd0, SEL_W'($urandom), FRAME_W'($urandom));
    add_item(ACT_SAMPLE, 4'd15, 15'h7FFF, SEL_W'($urandom), FRAME_W'($urandom));
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      n = 120;
      case (ph)
        0: period = 16'd0;
        1: begin
          period = 16'hFFFF;
          n = 30;
        end
        2: period = 16'd1;
        3: period = 16'd2;
        default: period = PERIOD_W'($urandom_range(1, 4));
      endcase
      idle_on = (ph % 4 != 2);
      write_reg(CFG_PERIOD, period);
      write_reg(CFG_MIDI, (ph == 1) ? 16'hFFFF : CFG_W'($urandom));
      @(posedge clk_i);
      add_random_items(n);
      wait_drained();
    end

    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/cvcc_pkg.sv
hw/rtl/cvcc_sent_ram.sv
hw/rtl/cvcc_quant.sv
hw/rtl/cv_to_midi_cc_converter.sv
sim/testbench.sv
